[rtl/periodic_task_release_scheduler_unit_macros.svh]
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_UNIT_MACROS_SVH

// consequent holds in the cycle after the antecedent
`define PTRS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PTRS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/ptrs_pkg.sv]
`default_nettype none

package ptrs_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam logic [15:0] INTERVAL_RESET = 16'd10;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_PICK  = 2'd2;
   localparam logic [1:0] REQ_BLOCK = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NONE     = 2'd2;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd3;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_ADD_RD    = 4'd2;
   localparam logic [3:0] OP_ADD_SHIFT = 4'd3;
   localparam logic [3:0] OP_ADD_PUT   = 4'd4;
   localparam logic [3:0] OP_WALK_RD   = 4'd5;
   localparam logic [3:0] OP_WALK_STEP = 4'd6;
   localparam logic [3:0] OP_PICK      = 4'd7;
   localparam logic [3:0] OP_BLK_RD    = 4'd8;
   localparam logic [3:0] OP_BLK_WR    = 4'd9;
   localparam logic [3:0] OP_FINISH    = 4'd10;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] period;
      logic [15:0] countdown;
      logic        ready;
   } slot_entry_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       full;
      logic       held_zero;
      logic       pos_one;
      logic       greater;
      logic       slot_bad;
      logic       last;
      logic       do_pick;
      logic       found;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[rtl/ptrs_ctrl.sv]
`default_nettype none
`include "periodic_task_release_scheduler_unit_macros.svh"

module ptrs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire ptrs_pkg::ctrl_stat_type stat,
   output logic                         busy,
   output ptrs_pkg::ctrl_cmd_type       cmd
);
   import ptrs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_ADD_CMP  = 3'd2;
   localparam logic [2:0] ST_ADD_PUT  = 3'd3;
   localparam logic [2:0] ST_WALK     = 3'd4;
   localparam logic [2:0] ST_PICK     = 3'd5;
   localparam logic [2:0] ST_BLK_WR   = 3'd6;
   localparam logic [2:0] ST_FIN      = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] status_ff;
   logic [1:0] status_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd.op     = OP_NONE;
      cmd.status = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op    = OP_LOAD;
               status_in = STATUS_OK;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.req_type)
               REQ_ADD: begin
                  if (stat.full) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_FIN;
                  end else if (stat.held_zero) begin
                     state_in = ST_ADD_PUT;
                  end else begin
                     cmd.op   = OP_ADD_RD;
                     state_in = ST_ADD_CMP;
                  end
               end
               REQ_TICK, REQ_PICK: begin
                  if (stat.held_zero) begin
                     state_in = ST_PICK;
                  end else begin
                     cmd.op   = OP_WALK_RD;
                     state_in = ST_WALK;
                  end
               end
               REQ_BLOCK: begin
                  if (stat.slot_bad) begin
                     status_in = STATUS_BAD_SLOT;
                     state_in  = ST_FIN;
                  end else begin
                     cmd.op   = OP_BLK_RD;
                     state_in = ST_BLK_WR;
                  end
               end
            endcase
         end
         ST_ADD_CMP: begin
            // shift the lower priority entry up one slot, or drop the new task in
            if (stat.greater) begin
               cmd.op   = OP_ADD_SHIFT;
               state_in = stat.pos_one ? ST_ADD_PUT : ST_ADD_CMP;
            end else begin
               cmd.op   = OP_ADD_PUT;
               state_in = ST_FIN;
            end
         end
         ST_ADD_PUT: begin
            cmd.op   = OP_ADD_PUT;
            state_in = ST_FIN;
         end
         ST_WALK: begin
            cmd.op = OP_WALK_STEP;
            if (stat.last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.op = OP_PICK;
            if (stat.do_pick && !stat.found) begin
               status_in = STATUS_NONE;
            end
            state_in = ST_FIN;
         end
         ST_BLK_WR: begin
            cmd.op   = OP_BLK_WR;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_FINISH;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `PTRS_ASSERT_NEXT(a_accept_dispatch, start && !busy, state_ff == ST_DISPATCH, "request not dispatched")
   `PTRS_ASSERT_NEXT(a_walk_ends_in_pick, state_ff == ST_WALK && stat.last, state_ff == ST_PICK, "walk overran table")
   `PTRS_ASSERT_NEXT(a_finish_frees, state_ff == ST_FIN, !busy, "busy held after finish")
   `PTRS_ASSERT_SAME(a_load_when_idle, cmd.op == OP_LOAD, start && !busy, "load without accepted request")

endmodule

`default_nettype wire

[rtl/ptrs_datapath.sv]
`default_nettype none

module ptrs_datapath #(
   parameter int SLOT_COUNT = ptrs_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ptrs_pkg::ctrl_cmd_type cmd,
   output ptrs_pkg::ctrl_stat_type     stat,
   input  wire logic [15:0]            preempt_interval,
   input  wire logic [1:0]             req_type,
   input  wire logic [7:0]             req_task_priority,
   input  wire logic [15:0]            req_task_period,
   input  wire logic [15:0]            req_start_countdown,
   input  wire logic                   req_start_ready,
   input  wire logic [3:0]             req_block_slot,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_picked_valid,
   output logic [3:0]                  rsp_picked_slot,
   output logic [4:0]                  rsp_task_total,
   output logic [31:0]                 rsp_tick_value
);
   import ptrs_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int CMP_W = CNT_W + 4;

   slot_entry_type mem [SLOT_COUNT];
   slot_entry_type rd_data_ff;

   logic           rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_entry_type wr_data;

   logic [1:0]       req_type_ff, req_type_in;
   slot_entry_type   new_entry_ff, new_entry_in;
   logic [3:0]       block_slot_ff, block_slot_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [31:0]      tick_ff, tick_in;
   logic [15:0]      tsp_ff, tsp_in;
   logic             do_pick_ff, do_pick_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_slot_ff, found_slot_in;
   slot_entry_type   found_entry_ff, found_entry_in;
   logic             picked_valid_ff, picked_valid_in;
   logic [IDX_W-1:0] picked_slot_ff, picked_slot_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_picked_valid_ff, rsp_picked_valid_in;
   logic [3:0]       rsp_picked_slot_ff, rsp_picked_slot_in;
   logic [4:0]       rsp_task_total_ff, rsp_task_total_in;
   logic [31:0]      rsp_tick_value_ff, rsp_tick_value_in;

   logic [CNT_W-1:0] idx_dec;
   logic [CNT_W-1:0] idx_dec2;
   logic [CNT_W-1:0] idx_inc;
   logic [15:0]      tsp_inc;
   logic [CMP_W-1:0] slot_ext;
   logic [CMP_W-1:0] held_ext;
   logic [CMP_W-1:0] picked_ext;
   logic [IDX_W-1:0] blk_addr;
   slot_entry_type   upd;
   slot_entry_type   cleared;

   assign idx_dec    = idx_ff - CNT_W'(1);
   assign idx_dec2   = idx_ff - CNT_W'(2);
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign tsp_inc    = tsp_ff + 16'd1;
   assign slot_ext   = CMP_W'(block_slot_ff);
   assign held_ext   = CMP_W'(held_ff);
   assign picked_ext = CMP_W'(picked_slot_ff);
   assign blk_addr   = slot_ext[IDX_W-1:0];

   // countdown step of one slot on a tick
   always_comb begin
      upd = rd_data_ff;
      if (req_type_ff == REQ_TICK) begin
         if (rd_data_ff.countdown <= 16'd1) begin
            upd.countdown = rd_data_ff.period;
            upd.ready     = 1'b1;
         end else begin
            upd.countdown = rd_data_ff.countdown - 16'd1;
         end
      end
   end

   always_comb begin
      cleared       = rd_data_ff;
      cleared.ready = 1'b0;
   end

   assign stat.req_type  = req_type_ff;
   assign stat.full      = (held_ff == CNT_W'(SLOT_COUNT));
   assign stat.held_zero = (held_ff == '0);
   assign stat.pos_one   = (idx_ff == CNT_W'(1));
   assign stat.greater   = (rd_data_ff.prio > new_entry_ff.prio);
   assign stat.slot_bad  = (slot_ext >= held_ext);
   assign stat.last      = (idx_inc == held_ff);
   assign stat.do_pick   = do_pick_ff;
   assign stat.found     = found_ff;

   always_comb begin
      rd_en               = 1'b0;
      rd_addr             = idx_ff[IDX_W-1:0];
      wr_en               = 1'b0;
      wr_addr             = idx_ff[IDX_W-1:0];
      wr_data             = new_entry_ff;
      req_type_in         = req_type_ff;
      new_entry_in        = new_entry_ff;
      block_slot_in       = block_slot_ff;
      held_in             = held_ff;
      idx_in              = idx_ff;
      tick_in             = tick_ff;
      tsp_in              = tsp_ff;
      do_pick_in          = do_pick_ff;
      found_in            = found_ff;
      found_slot_in       = found_slot_ff;
      found_entry_in      = found_entry_ff;
      picked_valid_in     = picked_valid_ff;
      picked_slot_in      = picked_slot_ff;
      rsp_valid_in        = 1'b0;
      rsp_status_in       = rsp_status_ff;
      rsp_picked_valid_in = rsp_picked_valid_ff;
      rsp_picked_slot_in  = rsp_picked_slot_ff;
      rsp_task_total_in   = rsp_task_total_ff;
      rsp_tick_value_in   = rsp_tick_value_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            req_type_in            = req_type;
            new_entry_in.prio      = req_task_priority;
            new_entry_in.period    = req_task_period;
            new_entry_in.countdown = req_start_countdown;
            new_entry_in.ready     = req_start_ready;
            block_slot_in          = req_block_slot;
            idx_in                 = (req_type == REQ_ADD) ? held_ff : '0;
            found_in               = 1'b0;
            picked_valid_in        = 1'b0;
            picked_slot_in         = '0;
            do_pick_in             = (req_type == REQ_PICK);
            if (req_type == REQ_TICK) begin
               tick_in = tick_ff + 32'd1;
               if (tsp_inc >= preempt_interval) begin
                  tsp_in     = 16'd0;
                  do_pick_in = 1'b1;
               end else begin
                  tsp_in = tsp_inc;
               end
            end
         end
         OP_ADD_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[IDX_W-1:0];
         end
         OP_ADD_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            rd_en   = !stat.pos_one;
            rd_addr = idx_dec2[IDX_W-1:0];
            idx_in  = idx_dec;
         end
         OP_ADD_PUT: begin
            wr_en   = 1'b1;
            held_in = held_ff + CNT_W'(1);
         end
         OP_WALK_RD: begin
            rd_en = 1'b1;
         end
         OP_WALK_STEP: begin
            wr_en   = (req_type_ff == REQ_TICK);
            wr_data = upd;
            rd_en   = !stat.last;
            rd_addr = idx_inc[IDX_W-1:0];
            idx_in  = idx_inc;
            // remember the first ready slot for the pick
            if (!found_ff && upd.ready) begin
               found_in       = 1'b1;
               found_slot_in  = idx_ff[IDX_W-1:0];
               found_entry_in = upd;
            end
         end
         OP_PICK: begin
            if (do_pick_ff && found_ff) begin
               wr_en           = 1'b1;
               wr_addr         = found_slot_ff;
               wr_data         = found_entry_ff;
               wr_data.ready   = 1'b0;
               picked_valid_in = 1'b1;
               picked_slot_in  = found_slot_ff;
            end
         end
         OP_BLK_RD: begin
            rd_en   = 1'b1;
            rd_addr = blk_addr;
         end
         OP_BLK_WR: begin
            wr_en   = 1'b1;
            wr_addr = blk_addr;
            wr_data = cleared;
         end
         OP_FINISH: begin
            rsp_valid_in        = 1'b1;
            rsp_status_in       = cmd.status;
            rsp_picked_valid_in = picked_valid_ff;
            rsp_picked_slot_in  = picked_ext[3:0];
            rsp_task_total_in   = held_ext[4:0];
            rsp_tick_value_in   = tick_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         idx_ff       <= '0;
         tick_ff      <= 32'd0;
         tsp_ff       <= 16'd0;
         do_pick_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         tsp_ff       <= tsp_in;
         do_pick_ff   <= do_pick_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff         <= req_type_in;
      new_entry_ff        <= new_entry_in;
      block_slot_ff       <= block_slot_in;
      found_slot_ff       <= found_slot_in;
      found_entry_ff      <= found_entry_in;
      picked_valid_ff     <= picked_valid_in;
      picked_slot_ff      <= picked_slot_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_picked_valid_ff <= rsp_picked_valid_in;
      rsp_picked_slot_ff  <= rsp_picked_slot_in;
      rsp_task_total_ff   <= rsp_task_total_in;
      rsp_tick_value_ff   <= rsp_tick_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_picked_valid = rsp_picked_valid_ff;
   assign rsp_picked_slot  = rsp_picked_slot_ff;
   assign rsp_task_total   = rsp_task_total_ff;
   assign rsp_tick_value   = rsp_tick_value_ff;

endmodule

`default_nettype wire

[rtl/periodic_task_release_scheduler_unit.sv]
// add shifts each lower priority entry up one slot in turn; tick and pick walk every held task,
// one slot a cycle; block reads one slot and clears its ready bit; refused requests go to finish
// throughput: one request at a time, start is taken again in the cycle of the result strobe
// rsp_valid is a single-cycle strobe; the receiver cannot stall it
// reset: synchronous, clears the task count, tick and pick counters; interval returns to 10
`default_nettype none

module periodic_task_release_scheduler_unit #(
   parameter int SLOT_COUNT = ptrs_pkg::SLOT_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_task_priority,
   input  wire logic [15:0] req_task_period,
   input  wire logic [15:0] req_start_countdown,
   input  wire logic        req_start_ready,
   input  wire logic [3:0]  req_block_slot,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_picked_valid,
   output logic [3:0]       rsp_picked_slot,
   output logic [4:0]       rsp_task_total,
   output logic [31:0]      rsp_tick_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ptrs_pkg::*;

   localparam logic [1:0] ADDR_INTERVAL = 2'd0;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic [15:0]   interval_ff;
   logic [15:0]   interval_in;

   always_comb begin
      interval_in = interval_ff;
      if (psel && penable && pwrite && pready && paddr == ADDR_INTERVAL) begin
         interval_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_INTERVAL) ? {16'd0, interval_ff} : 32'd0;

   ptrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   ptrs_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .preempt_interval    (interval_ff),
      .req_type            (req_type),
      .req_task_priority   (req_task_priority),
      .req_task_period     (req_task_period),
      .req_start_countdown (req_start_countdown),
      .req_start_ready     (req_start_ready),
      .req_block_slot      (req_block_slot),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_picked_valid    (rsp_picked_valid),
      .rsp_picked_slot     (rsp_picked_slot),
      .rsp_task_total      (rsp_task_total),
      .rsp_tick_value      (rsp_tick_value)
   );

endmodule

`default_nettype wire

[test/tb_periodic_task_release_scheduler_unit.sv]
`timescale 1ns / 1ps

module tb_periodic_task_release_scheduler_unit;
   import ptrs_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEFAULT;
   localparam logic [1:0] INTERVAL_ADDR = 2'd0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  prio;
      logic [15:0] period;
      logic [15:0] countdown;
      logic        ready;
      logic [3:0]  slot;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        picked_valid;
      logic [3:0]  picked_slot;
      logic [4:0]  task_total;
      logic [31:0] tick_value;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_TICK;
   logic [7:0]  req_task_priority = '0;
   logic [15:0] req_task_period = '0;
   logic [15:0] req_start_countdown = '0;
   logic        req_start_ready = 1'b0;
   logic [3:0]  req_block_slot = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_picked_valid;
   logic [3:0]  rsp_picked_slot;
   logic [4:0]  rsp_task_total;
   logic [31:0] rsp_tick_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // scheduler shadow state
   logic [7:0]  tbl_prio [SLOTS];
   logic [15:0] tbl_period [SLOTS];
   logic [15:0] tbl_countdown [SLOTS];
   logic        tbl_ready [SLOTS];
   int          held = 0;
   logic [31:0] ticks_total = '0;
   logic [15:0] since_pick = '0;
   logic [15:0] interval = INTERVAL_RESET;

   outcome_type pending_outcomes [$];
   int          errors = 0;

   periodic_task_release_scheduler_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_task_priority(req_task_priority),
      .req_task_period(req_task_period),
      .req_start_countdown(req_start_countdown),
      .req_start_ready(req_start_ready),
      .req_block_slot(req_block_slot),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_picked_valid(rsp_picked_valid),
      .rsp_picked_slot(rsp_picked_slot),
      .rsp_task_total(rsp_task_total),
      .rsp_tick_value(rsp_tick_value),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // first ready slot in priority order is taken and its ready bit cleared
   function automatic outcome_type with_pick(outcome_type o);
      for (int i = 0; i < held; i++) begin
         if (tbl_ready[i]) begin
            tbl_ready[i] = 1'b0;
            o.picked_valid = 1'b1;
            o.picked_slot = 4'(i);
            return o;
         end
      end
      o.status = STATUS_NONE;
      return o;
   endfunction

   function automatic outcome_type schedule_request(request_type r);
      outcome_type o;
      int pos;
      o = '0;
      o.status = STATUS_OK;
      case (r.kind)
         REQ_ADD: begin
            if (held >= SLOTS) begin
               o.status = STATUS_FULL;
            end else begin
               pos = held;
               // equal priorities stay behind the ones already held
               while (pos > 0 && tbl_prio[pos - 1] > r.prio) begin
                  tbl_prio[pos] = tbl_prio[pos - 1];
                  tbl_period[pos] = tbl_period[pos - 1];
                  tbl_countdown[pos] = tbl_countdown[pos - 1];
                  tbl_ready[pos] = tbl_ready[pos - 1];
                  pos--;
               end
               tbl_prio[pos] = r.prio;
               tbl_period[pos] = r.period;
               tbl_countdown[pos] = r.countdown;
               tbl_ready[pos] = r.ready;
               held++;
            end
         end
         REQ_TICK: begin
            ticks_total = ticks_total + 32'd1;
            for (int i = 0; i < held; i++) begin
               if (tbl_countdown[i] <= 16'd1) begin
                  tbl_countdown[i] = tbl_period[i];
                  tbl_ready[i] = 1'b1;
               end else begin
                  tbl_countdown[i] = tbl_countdown[i] - 16'd1;
               end
            end
            since_pick = since_pick + 16'd1;
            if (since_pick >= interval) begin
               since_pick = '0;
               o = with_pick(o);
            end
         end
         REQ_PICK: begin
            o = with_pick(o);
         end
         default: begin
            if (int'(r.slot) < held) tbl_ready[r.slot] = 1'b0;
            else o.status = STATUS_BAD_SLOT;
         end
      endcase
      o.task_total = 5'(held);
      o.tick_value = ticks_total;
      return o;
   endfunction

   task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding, status %0d tick %0h",
                     $time, rsp_status, rsp_tick_value);
         end else begin
            want = pending_outcomes.pop_front();
            flag_field("status", 32'(want.status), 32'(rsp_status));
            flag_field("picked_valid", 32'(want.picked_valid), 32'(rsp_picked_valid));
            flag_field("picked_slot", 32'(want.picked_slot), 32'(rsp_picked_slot));
            flag_field("task_total", 32'(want.task_total), 32'(rsp_task_total));
            flag_field("tick_value", want.tick_value, rsp_tick_value);
         end
      end
   end

   function automatic request_type noise_request();
      request_type r;
      r.kind = 2'($urandom);
      r.prio = 8'($urandom);
      r.period = 16'($urandom);
      r.countdown = 16'($urandom);
      r.ready = 1'($urandom);
      r.slot = 4'($urandom);
      return r;
   endfunction

   task automatic send_request(request_type r);
      @(posedge clock);
      start <= 1'b1;
      req_type <= r.kind;
      req_task_priority <= r.prio;
      req_task_period <= r.period;
      req_start_countdown <= r.countdown;
      req_start_ready <= r.ready;
      req_block_slot <= r.slot;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      pending_outcomes.push_back(schedule_request(r));
   endtask

   task automatic send_add(logic [7:0] prio, logic [15:0] period, logic [15:0] countdown,
                           logic ready);
      request_type r;
      r = noise_request();
      r.kind = REQ_ADD;
      r.prio = prio;
      r.period = period;
      r.countdown = countdown;
      r.ready = ready;
      send_request(r);
   endtask

   task automatic send_op(logic [1:0] kind, logic [3:0] slot);
      request_type r;
      r = noise_request();
      r.kind = kind;
      r.slot = slot;
      send_request(r);
   endtask

   task automatic await_idle();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic read_interval(logic [15:0] want);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= INTERVAL_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      flag_field("preempt_interval readback", 32'(want), 32'(prdata[15:0]));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_interval(logic [15:0] value);
      await_idle();
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= INTERVAL_ADDR;
      pwdata <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      interval = value;
      read_interval(value);
   endtask

   task automatic test_empty_table();
      read_interval(INTERVAL_RESET);
      send_op(REQ_PICK, 4'd0);
      send_op(REQ_BLOCK, 4'd0);
      send_op(REQ_BLOCK, 4'd15);
      // the tenth tick picks on the reset interval and finds nothing
      repeat (10) send_op(REQ_TICK, 4'd0);
   endtask

   task automatic test_insertion_order();
      send_add(8'd128, 16'd3, 16'd0, 1'b0);
      send_add(8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
      send_add(8'd0, 16'd0, 16'd1, 1'b0);
      send_add(8'd128, 16'd2, 16'd2, 1'b1);
      send_add(8'd64, 16'd1, 16'd5, 1'b0);
      send_op(REQ_BLOCK, 4'd3);
      send_op(REQ_BLOCK, 4'd5);
      send_op(REQ_PICK, 4'd0);
      send_op(REQ_PICK, 4'd0);
   endtask

   task automatic test_interval_extremes();
      write_interval(16'd0);
      repeat (2) send_op(REQ_TICK, 4'd0);
      write_interval(16'hFFFF);
      repeat (3) send_op(REQ_TICK, 4'd0);
      // count is now above the new interval, so the next tick picks
      write_interval(16'd2);
      send_op(REQ_TICK, 4'd0);
   endtask

   task automatic test_random_traffic();
      request_type r;
      int burst_left;
      int pick;
      logic [15:0] phase_interval [4];
      phase_interval[0] = 16'd1;
      phase_interval[1] = 16'($urandom_range(2, 12));
      phase_interval[2] = 16'hFFFF;
      phase_interval[3] = 16'($urandom_range(2, 6));
      burst_left = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_interval(phase_interval[phase]);
         for (int n = 0; n < 400; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
            end
            burst_left--;
            r = noise_request();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               r.kind = REQ_ADD;
               if ($urandom_range(0, 1) != 0) r.prio = 8'($urandom_range(0, 7));
               if ($urandom_range(0, 3) != 0) r.period = 16'($urandom_range(1, 12));
               else r.period = 16'($urandom_range(1, 65535));
               if ($urandom_range(0, 3) != 0) r.countdown = 16'($urandom_range(0, 12));
            end else if (pick < 55) begin
               r.kind = REQ_TICK;
            end else if (pick < 75) begin
               r.kind = REQ_PICK;
            end else begin
               r.kind = REQ_BLOCK;
            end
            send_request(r);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_insertion_order();
      test_interval_extremes();
      test_random_traffic();
      await_idle();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb_periodic_task_release_scheduler_unit: clean");
      end else begin
         $display("tb_periodic_task_release_scheduler_unit: errors");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_periodic_task_release_scheduler_unit: errors");
      $finish;
   end

endmodule

[periodic_task_release_scheduler_unit.f]
+incdir+rtl
rtl/ptrs_pkg.sv
rtl/ptrs_ctrl.sv
rtl/ptrs_datapath.sv
rtl/periodic_task_release_scheduler_unit.sv
test/tb_periodic_task_release_scheduler_unit.sv
